// ===== sv/kvc_pkg.sv =====
package kvc_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int KEY_W      = 32;
    localparam int KLEN_W     = 9;
    localparam int HANDLE_W   = 64;
    localparam int VLEN_W     = 21;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = KEY_W + HANDLE_W + VLEN_W;

    localparam int IN_FIELD_W  = KEY_W + KLEN_W + HANDLE_W + VLEN_W;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = HANDLE_W + VLEN_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = STATUS_W + 1;

    localparam logic [KLEN_W-1:0] KEY_LEN_MAX   = KLEN_W'(256);
    localparam logic [VLEN_W-1:0] MAX_LEN_RESET = VLEN_W'(1048576);

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_BAD_KEY   = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_DELETED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_DELETE,
        OP_BAD_KEY,
        OP_TOO_LARGE
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic scan_hit;
        logic scan_end;
        logic out_busy;
    } stat_t;

endpackage

// ===== sv/kvc_ram.sv =====
module kvc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/kvc_ctrl.sv =====
module kvc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  kvc_pkg::stat_t stat,
    output kvc_pkg::cmd_t  cmd
);

    import kvc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (stat.in_op inside {OP_READ, OP_DELETE}) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (stat.scan_hit || stat.scan_end) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
            end
            S_FINISH: begin
                cmd.finish = !stat.out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/kvc_datapath.sv =====
module kvc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tuser,
    input  logic [kvc_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kvc_pkg::OUT_USER_W-1:0]  m_tuser,
    output logic [kvc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    input  logic [kvc_pkg::VLEN_W-1:0]      cfg_data,
    input  kvc_pkg::cmd_t                   cmd,
    output kvc_pkg::stat_t                  stat
);

    import kvc_pkg::*;

    // input unpacking
    logic [KEY_W-1:0]    in_key;
    logic [KLEN_W-1:0]   in_klen;
    logic [HANDLE_W-1:0] in_handle;
    logic [VLEN_W-1:0]   in_vlen;
    op_t                 in_op;

    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_klen   = s_tdata[KEY_W+KLEN_W-1:KEY_W];
    assign in_handle = s_tdata[KEY_W+KLEN_W+HANDLE_W-1:KEY_W+KLEN_W];
    assign in_vlen   = s_tdata[IN_FIELD_W-1:KEY_W+KLEN_W+HANDLE_W];

    logic [VLEN_W-1:0] max_len_reg;

    always_comb begin
        if (in_klen == '0 || in_klen > KEY_LEN_MAX) begin
            in_op = OP_BAD_KEY;
        end else if (!s_tuser) begin
            in_op = OP_READ;
        end else if (in_vlen > max_len_reg) begin
            in_op = OP_TOO_LARGE;
        end else if (in_vlen == '0) begin
            in_op = OP_DELETE;
        end else begin
            in_op = OP_WRITE;
        end
    end

    // item registers
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [VLEN_W-1:0]   vlen_reg;

    // entry state
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   pos_reg;

    // scan state
    logic [IDX_W-1:0] addr_reg;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_last_reg;

    // found entry
    logic                hit_reg;
    logic [HANDLE_W-1:0] found_handle_reg;
    logic [VLEN_W-1:0]   found_len_reg;

    // output register
    logic                m_tvalid_reg;
    status_t             m_status_reg;
    logic                m_hit_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [VLEN_W-1:0]   m_length_reg;

    // memory
    logic               ram_rd_en;
    logic               ram_wr_en;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic [KEY_W-1:0]    rd_tag;
    logic [HANDLE_W-1:0] rd_handle;
    logic [VLEN_W-1:0]   rd_len;
    logic                tag_eq;
    logic                read_hit;
    logic                issue_more;
    status_t             fin_status;

    assign issue_more  = issue_cnt_reg < CNT_W'(ENTRIES);
    assign ram_rd_en   = cmd.scan && issue_more;
    assign ram_wr_en   = cmd.finish && (op_reg == OP_WRITE);
    assign ram_wr_data = {vlen_reg, handle_reg, key_reg};

    kvc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_tag    = ram_rd_data[KEY_W-1:0];
    assign rd_handle = ram_rd_data[KEY_W+HANDLE_W-1:KEY_W];
    assign rd_len    = ram_rd_data[ENTRY_W-1:KEY_W+HANDLE_W];

    assign tag_eq   = rd_pend_reg && valid_reg[rd_addr_reg] && (rd_tag == key_reg);
    assign read_hit = tag_eq && (key_reg != '0) && (op_reg == OP_READ);

    always_comb begin
        case (op_reg)
            OP_BAD_KEY:        fin_status = STAT_BAD_KEY;
            OP_TOO_LARGE:      fin_status = STAT_TOO_LARGE;
            OP_DELETE:         fin_status = STAT_DELETED;
            OP_READ, OP_WRITE: fin_status = STAT_DONE;
            default:           fin_status = STAT_DONE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= MAX_LEN_RESET;
            valid_reg    <= '0;
            pos_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_len_reg <= cfg_data;
            end

            if (cmd.load) begin
                rd_pend_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_pend_reg <= issue_more;
            end

            if (cmd.scan && tag_eq && (op_reg == OP_DELETE)) begin
                valid_reg[rd_addr_reg] <= 1'b0;
            end

            if (ram_wr_en) begin
                valid_reg[pos_reg] <= 1'b1;
                if (pos_reg == IDX_W'(ENTRIES - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end

            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg           <= in_op;
            key_reg          <= in_key;
            handle_reg       <= in_handle;
            vlen_reg         <= in_vlen;
            addr_reg         <= pos_reg;
            issue_cnt_reg    <= '0;
            hit_reg          <= 1'b0;
            found_handle_reg <= '0;
            found_len_reg    <= '0;
        end else if (cmd.scan) begin
            if (issue_more) begin
                rd_addr_reg   <= addr_reg;
                rd_last_reg   <= (issue_cnt_reg == CNT_W'(ENTRIES - 1));
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                if (addr_reg == '0) begin
                    addr_reg <= IDX_W'(ENTRIES - 1);
                end else begin
                    addr_reg <= addr_reg - 1'b1;
                end
            end
            if (read_hit) begin
                hit_reg          <= 1'b1;
                found_handle_reg <= rd_handle;
                found_len_reg    <= rd_len;
            end
        end

        if (cmd.finish) begin
            m_status_reg <= fin_status;
            m_hit_reg    <= hit_reg;
            m_handle_reg <= found_handle_reg;
            m_length_reg <= found_len_reg;
        end
    end

    assign stat.in_op    = in_op;
    assign stat.scan_hit = read_hit;
    assign stat.scan_end = rd_pend_reg && rd_last_reg;
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {m_hit_reg, m_status_reg};
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, m_length_reg, m_handle_reg};

endmodule

// ===== sv/fifo_ring_key_value_cache.sv =====
// flow: a write or a rejected item goes from acceptance straight to the finish state,
//   which loads its result into the output register once that register is free; a read
//   or a delete first scans the entry ring one tag per cycle through the single read port
//   of the entry ram, up to ENTRIES reads. Only one transaction is in work at a time; the
//   next is taken once the result sits in the output register
// reset: aresetn (synchronous, active low) marks every entry empty, clears the write pointer
//   and sets max_value_length to 1048576; the entry ram itself is not swept
module fifo_ring_key_value_cache (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input transactions
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action
    input  logic                            s_tuser,
    // key_hash [31:0], key_length [40:32], value_handle [104:41], value_length [125:105]
    input  logic [kvc_pkg::IN_DATA_W-1:0]   s_tdata,

    // result transactions
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], hit [2]
    output logic [kvc_pkg::OUT_USER_W-1:0]  m_tuser,
    // found_handle [63:0], found_length [84:64]
    output logic [kvc_pkg::OUT_DATA_W-1:0]  m_tdata,

    // max_value_length write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kvc_pkg::VLEN_W-1:0]      cfg_data
);

    import kvc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // the register is always writable; software must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    // sequencer: idle, scan of the ring, result hand-off
    kvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry ram, valid bits, write pointer, compare and output register
    kvc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
